@@ hw/rtl/slf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slf_pkg
// Types and constants shared by the log stream token parser.
// ----------------------------------------------------------------------------
package slf_pkg;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1000;
    localparam logic [15:0] CLASS_MAX     = 16'hFFFF;
    localparam logic [1:0]  HDR_LAST_POS  = 2'd3;

    localparam logic [7:0] CH_INT      = 8'h23;  // '#'
    localparam logic [7:0] CH_DOUBLE   = 8'h5E;  // '^'
    localparam logic [7:0] CH_CLASS    = 8'h25;  // '%'
    localparam logic [7:0] CH_INSTANCE = 8'h40;  // '@'
    localparam logic [7:0] CH_ARRAY    = 8'h28;  // '('
    localparam logic [7:0] CH_QUOTE    = 8'h22;  // '"'
    localparam logic [7:0] CH_STAR     = 8'h2A;  // '*'
    localparam logic [7:0] CH_DASH     = 8'h2D;  // '-'
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_EOT      = 8'h04;
    localparam logic [7:0] CH_ZERO     = 8'h30;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_TOKENS  = 2'd1,
        PH_BODY    = 2'd2,
        PH_STOPPED = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        K_INT        = 4'd0,
        K_DOUBLE     = 4'd1,
        K_CLASSNAME  = 4'd2,
        K_INSTANCE   = 4'd3,
        K_STRING     = 4'd4,
        K_ARRAY      = 4'd5,
        K_NULL       = 4'd6,
        K_BODY       = 4'd7,
        K_END        = 4'd8,
        K_BADHDR     = 4'd9,
        K_UNEXPECTED = 4'd10
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic [15:0] class_number;
        logic [7:0]  body_byte;
        logic        body_last;
        logic        oversized;
    } token_t;

    // header text "SLF0"
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h53;
            2'd1:    b = 8'h4C;
            2'd2:    b = 8'h46;
            default: b = 8'h30;
        endcase
        return b;
    endfunction

    function automatic logic is_lower_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic is_any_hex(input logic [7:0] c);
        return is_lower_hex(c) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/slf_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slf_in_stage
// Input register: holds one stream byte until the parse core takes it.
// ----------------------------------------------------------------------------
module slf_in_stage
    import slf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       consume,
    output logic            item_valid,
    output logic [7:0]      item_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       load;

    assign in_stall   = valid_reg && !consume;
    assign load       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load || consume)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/slf_parse_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slf_parse_core
// Parser state and per-byte decode: header check, number accumulation,
// terminator decode and body pass-through.
// ----------------------------------------------------------------------------
module slf_parse_core
    import slf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire logic [7:0]  item_byte,
    input  wire logic        load_ok,
    input  wire logic [15:0] max_len,
    output logic             consume,
    output logic             res_valid,
    output token_t           res,
    output phase_t           phase
);

    phase_t      phase_reg,   phase_next;
    logic [1:0]  hpos_reg,    hpos_next;
    logic [63:0] acc_reg,     acc_next;
    logic        innum_reg,   innum_next;
    logic [63:0] remain_reg,  remain_next;
    logic [15:0] cls_reg,     cls_next;

    logic [63:0] digit;
    logic [63:0] acc_x10;
    logic [7:0]  c;

    assign c       = item_byte;
    assign consume = item_valid && load_ok;
    assign phase   = phase_reg;
    assign digit   = {56'd0, c} - {56'd0, CH_ZERO};
    assign acc_x10 = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hpos_reg   <= 2'd0;
            acc_reg    <= 64'd0;
            innum_reg  <= 1'b0;
            remain_reg <= 64'd0;
            cls_reg    <= 16'd1;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            remain_reg <= remain_next;
            cls_reg    <= cls_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        acc_next    = acc_reg;
        innum_next  = innum_reg;
        remain_next = remain_reg;
        cls_next    = cls_reg;
        res_valid   = 1'b0;
        res         = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (c != magic_byte(hpos_reg))
                begin
                    phase_next    = PH_STOPPED;
                    res_valid     = 1'b1;
                    res.kind      = K_BADHDR;
                    res.body_byte = c;
                end
                else if (hpos_reg == HDR_LAST_POS)
                begin
                    hpos_next  = 2'd0;
                    phase_next = PH_TOKENS;
                end
                else
                begin
                    hpos_next = hpos_reg + 2'd1;
                end
            end

            PH_BODY:
            begin
                res_valid     = 1'b1;
                res.kind      = K_BODY;
                res.body_byte = c;
                if (remain_reg <= 64'd1)
                begin
                    remain_next   = 64'd0;
                    phase_next    = PH_TOKENS;
                    res.body_last = 1'b1;
                end
                else
                begin
                    remain_next = remain_reg - 64'd1;
                end
            end

            PH_TOKENS:
            begin
                if (innum_reg)
                begin
                    if (is_any_hex(c))
                    begin
                        acc_next = acc_x10;
                    end
                    else
                    begin
                        innum_next = 1'b0;
                        acc_next   = 64'd0;
                        res_valid  = 1'b1;
                        res.value  = acc_reg;
                        case (c)
                            CH_INT:      res.kind = K_INT;
                            CH_DOUBLE:   res.kind = K_DOUBLE;
                            CH_INSTANCE: res.kind = K_INSTANCE;
                            CH_ARRAY:    res.kind = K_ARRAY;
                            CH_CLASS:
                            begin
                                res.kind         = K_CLASSNAME;
                                res.class_number = cls_reg;
                                if (cls_reg != CLASS_MAX)
                                begin
                                    cls_next = cls_reg + 16'd1;
                                end
                                if (acc_reg != 64'd0)
                                begin
                                    remain_next = acc_reg;
                                    phase_next  = PH_BODY;
                                end
                            end
                            CH_QUOTE, CH_STAR:
                            begin
                                res.kind      = K_STRING;
                                res.oversized = (acc_reg > {48'd0, max_len});
                                if (acc_reg != 64'd0)
                                begin
                                    remain_next = acc_reg;
                                    phase_next  = PH_BODY;
                                end
                            end
                            default:
                            begin
                                res.kind      = K_UNEXPECTED;
                                res.body_byte = c;
                                phase_next    = PH_STOPPED;
                            end
                        endcase
                    end
                end
                else if (is_lower_hex(c))
                begin
                    innum_next = 1'b1;
                    acc_next   = digit;
                end
                else if (c == CH_DASH)
                begin
                    res_valid = 1'b1;
                    res.kind  = K_NULL;
                end
                else if (c == CH_NEWLINE)
                begin
                    res_valid = 1'b0;
                end
                else if ((c == CH_NUL) || (c == CH_EOT))
                begin
                    res_valid  = 1'b1;
                    res.kind   = K_END;
                    phase_next = PH_STOPPED;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.kind      = K_UNEXPECTED;
                    res.body_byte = c;
                    phase_next    = PH_STOPPED;
                end
            end

            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        if (!item_valid)
        begin
            res_valid = 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/slf_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slf_out_stage
// Result register: holds one token item until the consumer takes it.
// ----------------------------------------------------------------------------
module slf_out_stage
    import slf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   consume,
    input  wire logic   res_valid,
    input  wire token_t res,
    output logic        load_ok,
    output logic        out_valid,
    input  wire logic   out_stall,
    output token_t      out_tok
);

    logic   valid_reg;
    token_t tok_reg;

    assign load_ok   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= consume && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && consume && res_valid)
        begin
            tok_reg <= res;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/slf_token_stream_parser_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slf_token_stream_parser_top
// Log stream token parser: header check, number tokens, body pass-through.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_stall, in_byte    | byte in
//  out     | out_valid, out_stall, token_*  | token out
//  cfg     | cfg_valid, cfg_ready, cfg_data | register write
//
//  One byte per cycle unless out_stall holds the flow; each byte passes the input register, then the result register.
//  Multiply-by-ten accumulate and byte decode sit between the two registers.
//  Reset: header check, class index 1, max_string_length 1000.
//  out_stall holds the result register and stalls the input once both fill.
// ----------------------------------------------------------------------------
module slf_token_stream_parser_top
    import slf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       token_kind,
    output logic [63:0]      token_value,
    output logic [15:0]      class_number,
    output logic [7:0]       body_byte,
    output logic             body_last,
    output logic             oversized,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] max_len_reg;
    logic        item_valid;
    logic [7:0]  item_byte;
    logic        consume;
    logic        load_ok;
    logic        res_valid;
    token_t      res;
    token_t      out_tok;
    phase_t      phase;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    slf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .consume    (consume),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    slf_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .load_ok    (load_ok),
        .max_len    (max_len_reg),
        .consume    (consume),
        .res_valid  (res_valid),
        .res        (res),
        .phase      (phase)
    );

    slf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .consume   (consume),
        .res_valid (res_valid),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_tok   (out_tok)
    );

    assign token_kind   = out_tok.kind;
    assign token_value  = out_tok.value;
    assign class_number = out_tok.class_number;
    assign body_byte    = out_tok.body_byte;
    assign body_last    = out_tok.body_last;
    assign oversized    = out_tok.oversized;

`ifndef SYNTHESIS
    // once stopped, the parser stays stopped until reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase == PH_STOPPED |=> phase == PH_STOPPED)
        else $error("parser left stopped phase");

    // nothing is produced while stopped
    a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase == PH_STOPPED |-> !(consume && res_valid))
        else $error("result produced while stopped");

    a_last_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_last |-> token_kind == K_BODY)
        else $error("body_last on a non-body item");

    a_over_string: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && oversized |-> token_kind == K_STRING)
        else $error("oversized on a non-string item");
`endif

endmodule
`default_nettype wire
